@@ sv/positional_list_insert_delete_macros.svh @@
// Assertion macros shared by the positional list checker.
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLID_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLID_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define PLID_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/plid_pkg.sv @@
// Package with sizes, codes and types of the positional list.
`timescale 1ns / 1ps
`default_nettype none
package plid_pkg;
    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W      = $clog2(DEPTH + 1);
    localparam int CMP_W      = (LEN_W + 1 > 8) ? LEN_W + 1 : 8;
    localparam int GROUP      = 8;
    localparam int NGROUPS    = (DEPTH + GROUP - 1) / GROUP;

    localparam logic [1:0] MODE_DELETE = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef logic [WORD_WIDTH-1:0] word_t;

    typedef struct packed {
        logic             accept;
        logic             do_ins;
        logic             do_del;
        logic             do_tap;
        logic [IDX_W-1:0] pos;
        word_t            value;
    } cell_ctrl_t;

    function automatic word_t to_word(input logic [31:0] v);
        logic [63:0] v64;
        v64 = {32'd0, v};
        return v64[WORD_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] from_word(input word_t w);
        logic [63:0] w64;
        w64 = 64'(w);
        return w64[31:0];
    endfunction
endpackage
`default_nettype wire

@@ sv/plid_cell.sv @@
// One list cell: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module plid_cell (
    input  wire logic                      aclk,
    input  wire logic [plid_pkg::IDX_W-1:0] cell_idx,
    input  wire plid_pkg::cell_ctrl_t      ctrl,
    input  wire plid_pkg::word_t           word_left,
    input  wire plid_pkg::word_t           word_right,
    output plid_pkg::word_t                word_out,
    output plid_pkg::word_t                tap_out
);
    import plid_pkg::*;

    word_t word_reg, word_next;
    word_t tap_reg, tap_next;

    always_comb begin
        word_next = word_reg;
        if (ctrl.do_ins) begin
            if (cell_idx > ctrl.pos) begin
                word_next = word_left;
            end else if (cell_idx == ctrl.pos) begin
                word_next = ctrl.value;
            end
        end else if (ctrl.do_del) begin
            if (cell_idx >= ctrl.pos) begin
                word_next = word_right;
            end
        end
    end

    always_comb begin
        tap_next = tap_reg;
        if (ctrl.accept) begin
            tap_next = (ctrl.do_tap && cell_idx == ctrl.pos) ? word_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        tap_reg  <= tap_next;
    end

    assign word_out = word_reg;
    assign tap_out  = tap_reg;
endmodule
`default_nettype wire

@@ sv/plid_or_group.sv @@
// Registered OR over one group of cell taps.
`timescale 1ns / 1ps
`default_nettype none
module plid_or_group (
    input  wire logic            aclk,
    input  wire logic            enable,
    input  wire plid_pkg::word_t taps [plid_pkg::GROUP],
    output plid_pkg::word_t      group_out
);
    import plid_pkg::*;

    word_t group_reg, group_next;
    word_t acc;

    always_comb begin
        acc = '0;
        for (int k = 0; k < GROUP; k++) begin
            acc = acc | taps[k];
        end
        group_next = enable ? acc : group_reg;
    end

    always_ff @(posedge aclk) begin
        group_reg <= group_next;
    end

    assign group_out = group_reg;
endmodule
`default_nettype wire

@@ sv/positional_list_insert_delete.sv @@
// Top level of the positional list: a row of entry cells with a read gather tree.
//
// The list is a row of DEPTH cells, one entry each; an insert or delete moves
// every later entry by one place in the cycle the item is accepted. A result
// reaches the master side via the cell tap, group and output registers, and
// a new item is taken only once the last has left the cell tap stage: the
// read word is gathered from the cells through a registered two-level OR
// tree (groups of eight cells, then across groups), whose cell tap stage
// must empty before the next item can enter. An item can be taken while a
// finished result still waits on the master side. No clearing pass follows
// reset; entries past the list length hold whatever was last shifted into them.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_insert_delete (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: mode[1:0], position[8:2], entry_value[40:9], zero fill.
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: status[1:0], returned_value[33:2], current_length[40:34], zero fill.
    output logic [47:0]      m_tdata
);
    import plid_pkg::*;

    logic [1:0]  s_mode;
    logic [6:0]  s_position;
    logic [31:0] s_entry_value;

    assign s_mode        = s_tdata[1:0];
    assign s_position    = s_tdata[8:2];
    assign s_entry_value = s_tdata[40:9];

    logic [LEN_W-1:0] length_reg, length_next;
    logic             v1_reg, v1_next;
    logic             v2_reg, v2_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       st1_status_reg, st2_status_reg, out_status_reg;
    logic [LEN_W-1:0] st1_len_reg, st2_len_reg, out_len_reg;
    logic [31:0]      out_ret_reg;

    logic s_accept, out_free, v2_move, v1_move;
    logic [CMP_W-1:0] pos_ext, len_ext;
    logic [1:0]       status;
    logic             op_ins, op_del, op_tap;
    cell_ctrl_t       ctrl;

    assign s_tready = !v1_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign v2_move  = v2_reg && out_free;
    assign v1_move  = v1_reg && (!v2_reg || v2_move);

    assign pos_ext = CMP_W'(s_position);
    assign len_ext = CMP_W'(length_reg);

    always_comb begin
        status = ST_OK;
        op_ins = 1'b0;
        op_del = 1'b0;
        op_tap = 1'b0;
        if (s_mode == MODE_INSERT) begin
            if (pos_ext == '0 || pos_ext > len_ext + CMP_W'(1)) begin
                status = ST_BADPOS;
            end else if (len_ext >= CMP_W'(DEPTH)) begin
                status = ST_FULL;
            end else begin
                op_ins = 1'b1;
            end
        end else if (s_mode inside {MODE_DELETE, MODE_READ}) begin
            if (pos_ext == '0 || pos_ext > len_ext) begin
                status = ST_BADPOS;
            end else begin
                op_tap = 1'b1;
                op_del = (s_mode == MODE_DELETE);
            end
        end else begin
            status = ST_BADPOS;
        end
    end

    always_comb begin
        ctrl.accept = s_accept;
        ctrl.do_ins = s_accept && op_ins;
        ctrl.do_del = s_accept && op_del;
        ctrl.do_tap = op_tap;
        ctrl.pos    = IDX_W'(pos_ext - CMP_W'(1));
        ctrl.value  = to_word(s_entry_value);
    end

    always_comb begin
        length_next = length_reg;
        if (ctrl.do_ins) begin
            length_next = length_reg + LEN_W'(1);
        end else if (ctrl.do_del) begin
            length_next = length_reg - LEN_W'(1);
        end
    end

    word_t cell_word [DEPTH];
    word_t cell_tap  [NGROUPS*GROUP];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        word_t left_w, right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_word[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_word[i+1];
        end
        plid_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (IDX_W'(i)),
            .ctrl       (ctrl),
            .word_left  (left_w),
            .word_right (right_w),
            .word_out   (cell_word[i]),
            .tap_out    (cell_tap[i])
        );
    end

    for (genvar i = DEPTH; i < NGROUPS*GROUP; i++) begin : g_pad
        assign cell_tap[i] = '0;
    end

    word_t group_word [NGROUPS];

    for (genvar g = 0; g < NGROUPS; g++) begin : g_group
        word_t taps [GROUP];
        for (genvar k = 0; k < GROUP; k++) begin : g_tap
            assign taps[k] = cell_tap[g*GROUP + k];
        end
        plid_or_group u_group (
            .aclk      (aclk),
            .enable    (v1_move),
            .taps      (taps),
            .group_out (group_word[g])
        );
    end

    word_t gathered;

    always_comb begin
        gathered = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            gathered = gathered | group_word[g];
        end
    end

    always_comb begin
        v1_next = v1_reg;
        if (s_accept) begin
            v1_next = 1'b1;
        end else if (v1_move) begin
            v1_next = 1'b0;
        end
        v2_next = v2_reg;
        if (v1_move) begin
            v2_next = 1'b1;
        end else if (v2_move) begin
            v2_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (v2_move) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg  <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            length_reg  <= length_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_status_reg <= status;
            st1_len_reg    <= length_next;
        end
        if (v1_move) begin
            st2_status_reg <= st1_status_reg;
            st2_len_reg    <= st1_len_reg;
        end
        if (v2_move) begin
            out_status_reg <= st2_status_reg;
            out_len_reg    <= st2_len_reg;
            out_ret_reg    <= from_word(gathered);
        end
    end

    logic [CMP_W-1:0] out_len_ext;
    assign out_len_ext = CMP_W'(out_len_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_len_ext[6:0], out_ret_reg, out_status_reg};
endmodule
`default_nettype wire

@@ sv/plid_checker.sv @@
// Port-level checker for the positional list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_insert_delete_macros.svh"
module plid_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);
    import plid_pkg::*;

    logic s_accept;
    assign s_accept = s_tvalid && s_tready;

    `PLID_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "Result changed while stalled.")
    `PLID_ASSERT_IMPLY(a_err_zero, aclk, aresetn, m_tvalid && m_tdata[1:0] != ST_OK, m_tdata[33:2] == 32'd0, "Error result carries a nonzero word.")
    `PLID_ASSERT_IMPLY(a_len_bound, aclk, aresetn, m_tvalid, m_tdata[40:34] <= 7'(DEPTH), "Reported length exceeds the store depth.")
    `PLID_ASSERT_NEXT(a_gap, aclk, aresetn, s_accept, !s_tready, "Item taken while the gather stage is busy.")
    `PLID_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_tvalid, "Result valid right after reset.")
endmodule

bind positional_list_insert_delete plid_checker u_plid_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
